// ===== src/asod_pkg.sv =====
package asod_pkg;

    localparam int ACC_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FLAT_W     = 15;
    localparam int SQ_W       = 2 * ACC_W;
    localparam int JSQ_W      = SQ_W + 2;

    typedef enum logic [1:0] {
        OR_PORTRAIT       = 2'd0,
        OR_LANDSCAPE      = 2'd1,
        OR_PORTRAIT_FLIP  = 2'd2,
        OR_LANDSCAPE_FLIP = 2'd3
    } t_orient;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WAKE_JERK   = 3'd0;
    localparam t_cfg_idx CFG_SHAKE_JERK  = 3'd1;
    localparam t_cfg_idx CFG_REFRACTORY  = 3'd2;
    localparam t_cfg_idx CFG_PAIR_WINDOW = 3'd3;
    localparam t_cfg_idx CFG_COOLDOWN    = 3'd4;
    localparam t_cfg_idx CFG_FLAT_LEVEL  = 3'd5;
    localparam t_cfg_idx CFG_STABLE_TIME = 3'd6;

    localparam logic [CFG_DATA_W-1:0] RST_WAKE_JERK   = 16'd614;
    localparam logic [CFG_DATA_W-1:0] RST_SHAKE_JERK  = 16'd7373;
    localparam logic [CFG_DATA_W-1:0] RST_REFRACTORY  = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_PAIR_WINDOW = 16'd700;
    localparam logic [CFG_DATA_W-1:0] RST_COOLDOWN    = 16'd3000;
    localparam logic [FLAT_W-1:0]     RST_FLAT_LEVEL  = 15'd2048;
    localparam logic [CFG_DATA_W-1:0] RST_STABLE_TIME = 16'd500;

endpackage

// ===== src/asod_in_if.sv =====
interface asod_in_if;
    import asod_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic [TIME_W-1:0]        time_ms;
    logic                     rotation_lock;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, rotation_lock,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, time_ms, rotation_lock,
                  output ready);
endinterface

// ===== src/asod_out_if.sv =====
interface asod_out_if;
    import asod_pkg::*;

    logic       valid;
    logic       ready;
    logic       motion_wake;
    logic       double_shake;
    logic [1:0] orientation;
    logic       orientation_changed;

    modport source (output valid, motion_wake, double_shake, orientation,
                    orientation_changed, input ready);
    modport sink (input valid, motion_wake, double_shake, orientation,
                  orientation_changed, output ready);
endinterface

// ===== src/asod_cfg_if.sv =====
interface asod_cfg_if;
    import asod_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/accel_shake_orientation_detector.sv =====
// Channel  | Port   | Direction | Word
// ---------+--------+-----------+--------------------------------------------------
// sample   | i_smp  | in        | accel_x/y/z, time_ms, rotation_lock
// result   | o_res  | out       | motion_wake, double_shake, orientation, changed
// config   | i_cfg  | in        | register index and write data, always ready
//
// One sample is accepted per cycle while i_smp.ready is high; a result is offered once its
// sample has passed the input register, squares, threshold compare and the result register
// with the timing state.
// Reset is synchronous and returns the configuration registers, stage valids and tracking
// state to their defaults; the first sample after reset only primes the previous-sample store.
// Each stage holds only while the stage ahead is full, so a stalled result leaves room
// for three further samples before i_smp.ready falls.
module accel_shake_orientation_detector (
    input  logic            i_clk,
    input  logic            i_rst_n,
    asod_in_if.sink         i_smp,
    asod_out_if.source      o_res,
    asod_cfg_if.sink        i_cfg
);
    import asod_pkg::*;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_cfg_wake;
    logic [CFG_DATA_W-1:0] r_cfg_shake;
    logic [CFG_DATA_W-1:0] r_cfg_refr;
    logic [CFG_DATA_W-1:0] r_cfg_pair;
    logic [CFG_DATA_W-1:0] r_cfg_cool;
    logic [FLAT_W-1:0]     r_cfg_flat;
    logic [CFG_DATA_W-1:0] r_cfg_stable;
    logic [SQ_W-1:0]       r_wake_sq;
    logic [SQ_W-1:0]       r_shake_sq;

    // Stage valids and handshakes
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic acc_in, load2, load3, load4;

    // Previous sample store
    logic                    r_primed;
    logic signed [ACC_W-1:0] r_prev_x, r_prev_y, r_prev_z;

    // Stage 1
    logic                    r1_prime;
    logic signed [ACC_W-1:0] r1_x, r1_y;
    logic [ACC_W-1:0]        r1_dx, r1_dy, r1_dz;
    logic [TIME_W-1:0]       r1_time;
    logic                    r1_lock;

    // Stage 2
    logic              r2_prime;
    logic [SQ_W-1:0]   r2_sx, r2_sy, r2_sz;
    logic [TIME_W-1:0] r2_time;
    logic              r2_lock;
    logic              r2_flat;
    t_orient           r2_cand;

    // Stage 3
    logic              r3_prime;
    logic              r3_wake;
    logic              r3_shake;
    logic [TIME_W-1:0] r3_time;
    logic              r3_lock;
    logic              r3_flat;
    t_orient           r3_cand;

    // Tracking state
    logic [TIME_W-1:0] r_last_pulse, n_last_pulse;
    logic [TIME_W-1:0] r_cool, n_cool;
    t_orient           r_cur, n_cur;
    t_orient           r_cand, n_cand;
    logic [TIME_W-1:0] r_cand_since, n_cand_since;

    // Result register
    logic    r_res_wake, n_wake;
    logic    r_res_dbl, n_dbl;
    t_orient r_res_orient;
    logic    r_res_changed, n_changed;

    // Combinational helpers
    logic signed [ACC_W:0] dx_diff, dy_diff, dz_diff;
    logic [ACC_W-1:0]      dx_abs, dy_abs, dz_abs;
    logic [ACC_W-1:0]      mag_x, mag_y;
    logic                  flat_c;
    t_orient               cand_c;
    logic [JSQ_W-1:0]      jsq;
    logic [TIME_W-1:0]     since_pulse;
    logic [TIME_W-1:0]     cand_elapsed;
    logic                  pulse, dbl_hit, cand_new, do_switch;

    // Handshakes
    assign rdy4   = !r_v4 || o_res.ready;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign acc_in = i_smp.valid && rdy1;
    assign load2  = r_v1 && rdy2;
    assign load3  = r_v2 && rdy3;
    assign load4  = r_v3 && rdy4;

    assign i_smp.ready = rdy1;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid               = r_v4;
    assign o_res.motion_wake         = r_res_wake;
    assign o_res.double_shake        = r_res_dbl;
    assign o_res.orientation         = r_res_orient;
    assign o_res.orientation_changed = r_res_changed;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wake   <= RST_WAKE_JERK;
            r_cfg_shake  <= RST_SHAKE_JERK;
            r_cfg_refr   <= RST_REFRACTORY;
            r_cfg_pair   <= RST_PAIR_WINDOW;
            r_cfg_cool   <= RST_COOLDOWN;
            r_cfg_flat   <= RST_FLAT_LEVEL;
            r_cfg_stable <= RST_STABLE_TIME;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WAKE_JERK:   r_cfg_wake   <= i_cfg.data;
                CFG_SHAKE_JERK:  r_cfg_shake  <= i_cfg.data;
                CFG_REFRACTORY:  r_cfg_refr   <= i_cfg.data;
                CFG_PAIR_WINDOW: r_cfg_pair   <= i_cfg.data;
                CFG_COOLDOWN:    r_cfg_cool   <= i_cfg.data;
                CFG_FLAT_LEVEL:  r_cfg_flat   <= i_cfg.data[FLAT_W-1:0];
                CFG_STABLE_TIME: r_cfg_stable <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Squared thresholds follow the registers in the next cycle, well before any sample
    // written after the change reaches the compare stage.
    always_ff @(posedge i_clk) begin
        r_wake_sq  <= r_cfg_wake * r_cfg_wake;
        r_shake_sq <= r_cfg_shake * r_cfg_shake;
    end

    // Stage 1: axis deltas against the previous sample
    always_comb begin
        dx_diff = $signed({i_smp.accel_x[ACC_W-1], i_smp.accel_x})
                - $signed({r_prev_x[ACC_W-1], r_prev_x});
        dy_diff = $signed({i_smp.accel_y[ACC_W-1], i_smp.accel_y})
                - $signed({r_prev_y[ACC_W-1], r_prev_y});
        dz_diff = $signed({i_smp.accel_z[ACC_W-1], i_smp.accel_z})
                - $signed({r_prev_z[ACC_W-1], r_prev_z});
        dx_abs  = dx_diff[ACC_W] ? ACC_W'(-dx_diff) : dx_diff[ACC_W-1:0];
        dy_abs  = dy_diff[ACC_W] ? ACC_W'(-dy_diff) : dy_diff[ACC_W-1:0];
        dz_abs  = dz_diff[ACC_W] ? ACC_W'(-dz_diff) : dz_diff[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_prev_x <= i_smp.accel_x;
            r_prev_y <= i_smp.accel_y;
            r_prev_z <= i_smp.accel_z;
            r1_prime <= !r_primed;
            r1_x     <= i_smp.accel_x;
            r1_y     <= i_smp.accel_y;
            r1_dx    <= dx_abs;
            r1_dy    <= dy_abs;
            r1_dz    <= dz_abs;
            r1_time  <= i_smp.time_ms;
            r1_lock  <= i_smp.rotation_lock;
        end
    end

    // Stage 2: squares and the orientation candidate
    always_comb begin
        mag_x  = r1_x[ACC_W-1] ? ACC_W'(-r1_x) : r1_x;
        mag_y  = r1_y[ACC_W-1] ? ACC_W'(-r1_y) : r1_y;
        flat_c = (mag_x < {1'b0, r_cfg_flat}) && (mag_y < {1'b0, r_cfg_flat});
        if (mag_y >= mag_x) begin
            cand_c = r1_y[ACC_W-1] ? OR_PORTRAIT_FLIP : OR_PORTRAIT;
        end else begin
            cand_c = r1_x[ACC_W-1] ? OR_LANDSCAPE_FLIP : OR_LANDSCAPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r2_prime <= r1_prime;
            r2_sx    <= r1_dx * r1_dx;
            r2_sy    <= r1_dy * r1_dy;
            r2_sz    <= r1_dz * r1_dz;
            r2_time  <= r1_time;
            r2_lock  <= r1_lock;
            r2_flat  <= flat_c;
            r2_cand  <= cand_c;
        end
    end

    // Stage 3: squared jerk against the squared thresholds
    assign jsq = JSQ_W'(r2_sx) + JSQ_W'(r2_sy) + JSQ_W'(r2_sz);

    always_ff @(posedge i_clk) begin
        if (load3) begin
            r3_prime <= r2_prime;
            r3_wake  <= jsq > JSQ_W'(r_wake_sq);
            r3_shake <= jsq > JSQ_W'(r_shake_sq);
            r3_time  <= r2_time;
            r3_lock  <= r2_lock;
            r3_flat  <= r2_flat;
            r3_cand  <= r2_cand;
        end
    end

    // Stage 4: pulse timing and orientation tracking. Elapsed times wrap modulo 2^32.
    always_comb begin
        since_pulse  = r3_time - r_last_pulse;
        pulse        = r3_shake && (since_pulse > TIME_W'(r_cfg_refr));
        dbl_hit      = pulse && (r3_time > r_cool) && (since_pulse < TIME_W'(r_cfg_pair));
        cand_new     = (r3_cand != r_cand);
        // A fresh candidate restarts its timer at this sample, so it has waited zero.
        cand_elapsed = cand_new ? '0 : r3_time - r_cand_since;
        do_switch    = !r3_flat && (r3_cand != r_cur) && !r3_lock
                    && (cand_elapsed >= TIME_W'(r_cfg_stable));
    end

    always_comb begin
        n_last_pulse = r_last_pulse;
        n_cool       = r_cool;
        n_cur        = r_cur;
        n_cand       = r_cand;
        n_cand_since = r_cand_since;
        n_wake       = 1'b0;
        n_dbl        = 1'b0;
        n_changed    = 1'b0;
        if (!r3_prime) begin
            n_wake = r3_wake;
            if (pulse) begin
                n_last_pulse = r3_time;
                if (dbl_hit) begin
                    n_cool = r3_time + TIME_W'(r_cfg_cool);
                    n_dbl  = 1'b1;
                end
            end
            if (r3_flat) begin
                n_cand_since = r3_time;
            end else begin
                if (cand_new) begin
                    n_cand       = r3_cand;
                    n_cand_since = r3_time;
                end
                if (do_switch) begin
                    n_cur     = r3_cand;
                    n_changed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load4) begin
            r_res_wake    <= n_wake;
            r_res_dbl     <= n_dbl;
            r_res_orient  <= n_cur;
            r_res_changed <= n_changed;
        end
    end

    // Control and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_primed     <= 1'b0;
            r_last_pulse <= '0;
            r_cool       <= '0;
            r_cur        <= OR_LANDSCAPE;
            r_cand       <= OR_LANDSCAPE;
            r_cand_since <= '0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_smp.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (acc_in) begin
                r_primed <= 1'b1;
            end
            if (load4) begin
                r_last_pulse <= n_last_pulse;
                r_cool       <= n_cool;
                r_cur        <= n_cur;
                r_cand       <= n_cand;
                r_cand_since <= n_cand_since;
            end
        end
    end

    // Checks
    a_primed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag fell without reset");

    a_change_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load4 && n_changed) |=> (r_cur != $past(r_cur)))
        else $error("orientation change reported but orientation kept");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load4 |=> ($stable(r_last_pulse) && $stable(r_cool) && $stable(r_cur)))
        else $error("tracking state moved without a sample");

    a_dbl_is_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load4 && n_dbl) |=> (r_last_pulse == $past(r3_time)))
        else $error("double shake without recording the pulse time");

endmodule
